[hdl/lpdw_pkg.sv]
`timescale 1ns / 1ps

package lpdw_pkg;

  // operation codes
  localparam logic [1:0] OP_CHAR     = 2'd0;
  localparam logic [1:0] OP_UNSIGNED = 2'd1;
  localparam logic [1:0] OP_SIGNED   = 2'd2;

  // display bus constants
  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [7:0] ROW_OFFSET   = 8'h40;
  localparam logic [7:0] COL_MASK     = 8'h0F;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;

  // register select codes
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // number format
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned BITCNT_W   = $clog2(VALUE_W);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_ADDR  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

endpackage

[hdl/lcd_positioned_decimal_writer.sv]
`timescale 1ns / 1ps
// a character item is accepted in idle, then the address state writes the set-address command
// and the digit state the character; number items first run a bit-serial binary to bcd
// conversion (one value bit a cycle through the shift-add-3 register), then emit up to 7 writes,
// one a cycle while the output register is free; a new item is taken only back in idle
// reset: synchronous active-low rst_n clears the sequencer and the output valid

module lcd_positioned_decimal_writer #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, lowest bit up: column[7:0], row[15:8], value[31:16], digit_count[34:32], zero pad
  input  logic [39:0] in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: bus_byte[7:0]
  output logic [7:0]  out_tdata,
  // out_tuser: register_select[0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);

  import lpdw_pkg::*;

  // digit count cap, never more digits than a 16-bit value has
  localparam int unsigned CNT_CAP = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

  // input unpacking
  logic [7:0]         in_column;
  logic [7:0]         in_row;
  logic [VALUE_W-1:0] in_value;
  logic [2:0]         in_digit_count;
  logic [2:0]         cnt_sat;
  logic               in_neg;

  assign in_column      = in_tdata[7:0];
  assign in_row         = in_tdata[15:8];
  assign in_value       = in_tdata[31:16];
  assign in_digit_count = in_tdata[34:32];
  assign cnt_sat        = (in_digit_count > 3'(CNT_CAP)) ? 3'(CNT_CAP) : in_digit_count;
  assign in_neg         = (in_tuser == OP_SIGNED) && in_value[VALUE_W-1];

  // sequencer and item registers
  state_t              state_r, state_nxt;
  logic [1:0]          op_r;
  logic [7:0]          addr_r;
  logic [7:0]          char_r;
  logic                neg_r;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]  bin_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [BITCNT_W-1:0] bit_cnt_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r,  out_byte_nxt;
  logic       out_rs_r,    out_rs_nxt;
  logic       out_last_r,  out_last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             emit;
  logic [BCD_W-1:0] bcd_adj;
  logic [2:0]       digit_idx;
  logic [3:0]       digit_sel;

  // no item is taken while reset is held
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // add 3 to every bcd digit of 5 or more before the next shift
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                     : bcd_r[4*d +: 4];
    end
  end

  assign digit_idx = cnt_r - 3'd1;
  assign digit_sel = bcd_r[4*digit_idx +: 4];

  // sequencer: in the address, sign and digit states, one write into the output register each cycle it is free
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_rs_nxt    = out_rs_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            OP_CHAR:                state_nxt = ST_ADDR;
            OP_UNSIGNED, OP_SIGNED: state_nxt = ST_CONV;
            default:                state_nxt = ST_IDLE;
          endcase
          cnt_nxt = cnt_sat;
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == '0) state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (out_free) begin
          emit         = 1'b1;
          out_rs_nxt   = RS_COMMAND;
          out_byte_nxt = addr_r;
          if (op_r == OP_CHAR) begin
            out_last_nxt = 1'b0;
            state_nxt    = ST_DIGIT;
          end else if (neg_r) begin
            out_last_nxt = 1'b0;
            state_nxt    = ST_SIGN;
          end else begin
            out_last_nxt = (cnt_r == 3'd0);
            state_nxt    = (cnt_r == 3'd0) ? ST_IDLE : ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          emit         = 1'b1;
          out_rs_nxt   = RS_DATA;
          out_byte_nxt = ASCII_MINUS;
          out_last_nxt = (cnt_r == 3'd0);
          state_nxt    = (cnt_r == 3'd0) ? ST_IDLE : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          emit       = 1'b1;
          out_rs_nxt = RS_DATA;
          if (op_r == OP_CHAR) begin
            out_byte_nxt = char_r;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            // most significant requested digit first
            out_byte_nxt = ASCII_ZERO | {4'd0, digit_sel};
            out_last_nxt = (cnt_r == 3'd1);
            cnt_nxt      = cnt_r - 3'd1;
            if (cnt_r == 3'd1) state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_rs_r   <= out_rs_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      op_r      <= in_tuser;
      addr_r    <= SET_ADDR_CMD | (in_column & COL_MASK) | (in_row[0] ? ROW_OFFSET : 8'h00);
      char_r    <= in_value[7:0];
      neg_r     <= in_neg;
      // magnitude of a negative signed value, two's complement in 16 bits
      bin_r     <= in_neg ? (~in_value + 16'd1) : in_value;
      bcd_r     <= '0;
      bit_cnt_r <= BITCNT_W'(VALUE_W - 1);
    end else if (state_r == ST_CONV) begin
      // shift one magnitude bit into the bcd register per cycle
      bcd_r     <= {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_r     <= {bin_r[VALUE_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - BITCNT_W'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_rs_r;
  assign out_tlast  = out_last_r;

endmodule

[bench/lcd_positioned_decimal_writer_test.sv]
`timescale 1ns / 1ps

module lcd_positioned_decimal_writer_test;
  import lpdw_pkg::*;

  localparam int unsigned DIGIT_LIMIT  = 5;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned CALM_ITEMS   = 40;   // last items run with no idling
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned QUIET_LIMIT  = 2000; // cycles with no item moved
  localparam int unsigned DRAIN_CYCLES = 40;

  // one display bus write as seen on the result channel
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } lcd_write_t;

  // expected display writes, oldest first, and the check of each write
  class lcd_write_scoreboard;
    lcd_write_t  pending[$];
    int unsigned per_op[4];
    int unsigned writes_seen;
    int unsigned errors;

    function void note_request(logic [1:0] op, logic [7:0] col, logic [7:0] row,
                               logic [15:0] val, logic [2:0] cnt);
      lcd_write_t  seq[$];
      logic [7:0]  addr;
      logic [15:0] mag;
      int unsigned digits;
      int unsigned scale;
      per_op[op]++;
      if (op == OP_UNUSED) return;
      // set-address command first
      addr = SET_ADDR_CMD | (col & COL_MASK);
      if (row[0]) addr = addr | ROW_OFFSET;
      seq.push_back('{RS_COMMAND, addr, 1'b0});
      if (op == OP_CHAR) begin
        seq.push_back('{RS_DATA, val[7:0], 1'b0});
      end else begin
        digits = (cnt > DIGIT_LIMIT) ? DIGIT_LIMIT : cnt;
        mag = val;
        if (op == OP_SIGNED && val[15]) begin
          seq.push_back('{RS_DATA, ASCII_MINUS, 1'b0});
          mag = ~val + 16'd1; // 0x8000 maps onto itself, as wanted
        end
        scale = 1;
        for (int i = 1; i < digits; i++) scale = scale * 10;
        for (int i = 0; i < digits; i++) begin
          seq.push_back('{RS_DATA, ASCII_ZERO + 8'((int'(mag) / scale) % 10), 1'b0});
          scale = scale / 10;
        end
      end
      seq[seq.size() - 1].last = 1'b1;
      foreach (seq[i]) pending.push_back(seq[i]);
    endfunction

    function void check_write(logic rs, logic [7:0] data, logic last);
      lcd_write_t want;
      writes_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: write with nothing expected: rs=%0b byte=%02h last=%0b",
                 $time, rs, data, last);
        return;
      end
      want = pending.pop_front();
      if (rs !== want.rs) begin
        errors++;
        $display("%0t: register_select expected %0b, got %0b", $time, want.rs, rs);
      end
      if (data !== want.data) begin
        errors++;
        $display("%0t: bus_byte expected %02h, got %02h", $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b, got %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  // in_tdata, lowest bit up: column[7:0], row[15:8], value[31:16], digit_count[34:32], zero pad
  logic [39:0] in_tdata;
  // in_tuser: operation[1:0]
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  // out_tdata: bus_byte[7:0]
  logic [7:0]  out_tdata;
  // out_tuser: register_select[0]
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;

  lcd_write_scoreboard sb;

  // idling switches for each side, and the request for the long hold-off
  bit send_idle;
  bit recv_idle;
  bit hold_out;

  lcd_positioned_decimal_writer #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request, wait for the handshake, then note it
  task automatic send_request(input logic [1:0] op, input logic [7:0] col,
                              input logic [7:0] row, input logic [15:0] val,
                              input logic [2:0] cnt);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, cnt, val, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, col, row, val, cnt);
  endtask

  // numbers lean on the edges of the 16-bit range and of the sign
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'($urandom_range(0, 99));
      5: return 16'hFFFF - 16'($urandom_range(0, 99));
      default: return 16'($urandom);
    endcase
  endfunction

  // random request; the unused code is returned but not counted by the caller
  task automatic send_random(output logic [1:0] op);
    int unsigned pick;
    logic [2:0]  cnt;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_CHAR;
    else if (pick < 62) op = OP_UNSIGNED;
    else if (pick < 95) op = OP_SIGNED;
    else op = OP_UNUSED;
    // full digit count in one draw of three, any count from 0 to 7 otherwise
    cnt = ($urandom_range(0, 2) == 0) ? 3'(DIGIT_LIMIT) : 3'($urandom_range(0, 7));
    send_request(op, 8'($urandom), 8'($urandom), pick_value(), cnt);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_write(out_tuser, out_tdata, out_tlast);
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  op;
    int unsigned counted;
    sb = new();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_out  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_CHAR;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: characters, with high value bits and address bits that must be masked
    send_request(OP_CHAR,     8'h00, 8'h00, 16'h0041, 3'd0);
    send_request(OP_CHAR,     8'hFF, 8'hFF, 16'hFFFF, 3'd7);
    send_request(OP_CHAR,     8'h0F, 8'h01, 16'h00FF, 3'd5);
    send_request(OP_CHAR,     8'h10, 8'h02, 16'h7F00, 3'd2);
    // unsigned: zero digits, full range, dropped high digits, count saturation
    send_request(OP_UNSIGNED, 8'h03, 8'h00, 16'h0000, 3'd0);
    send_request(OP_UNSIGNED, 8'h05, 8'h01, 16'hFFFF, 3'd5);
    send_request(OP_UNSIGNED, 8'h07, 8'h00, 16'hFFFF, 3'd3);
    send_request(OP_UNSIGNED, 8'h08, 8'h01, 16'd12345, 3'd7);
    send_request(OP_UNSIGNED, 8'h09, 8'h00, 16'd12345, 3'd6);
    send_request(OP_UNSIGNED, 8'hF0, 8'hFE, 16'd9, 3'd1);
    send_request(OP_UNSIGNED, 8'h0A, 8'h01, 16'd0, 3'd5);
    // signed: most negative, -1, most positive, minus sign alone, saturated count
    send_request(OP_SIGNED,   8'h00, 8'h01, 16'h8000, 3'd5);
    send_request(OP_SIGNED,   8'h01, 8'h00, 16'hFFFF, 3'd1);
    send_request(OP_SIGNED,   8'h02, 8'h01, 16'h7FFF, 3'd5);
    send_request(OP_SIGNED,   8'h04, 8'h00, 16'hFFFF, 3'd0);
    send_request(OP_SIGNED,   8'h06, 8'h01, 16'h0000, 3'd0);
    send_request(OP_SIGNED,   8'h0B, 8'h00, 16'h8000, 3'd7);
    send_request(OP_SIGNED,   8'h0C, 8'h01, 16'hD8F1, 3'd4);
    send_request(OP_SIGNED,   8'h0D, 8'h00, 16'd4321, 3'd5);
    // unused code: accepted and dropped
    send_request(OP_UNUSED,   8'h05, 8'h01, 16'h1234, 3'd3);
    send_request(OP_UNUSED,   8'hFF, 8'hFF, 16'hFFFF, 3'd7);
    send_request(OP_CHAR,     8'h0E, 8'h00, 16'h0030, 3'd0);

    // back pressure: receiver holds off while requests keep coming, so the block fills up
    hold_out = 1'b1;
    counted = 0;
    repeat (20) begin
      send_random(op);
      if (op != OP_UNUSED) counted++;
    end

    // random part, idling switched per stretch, the tail without idling
    while (counted < RANDOM_ITEMS) begin
      if (counted % 30 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      if (counted >= RANDOM_ITEMS - CALM_ITEMS) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      send_random(op);
      if (op != OP_UNUSED) counted++;
    end
    in_tvalid <= 1'b0;

    // drain, then give a stray write the chance to show up
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d character, %0d unsigned, %0d signed and %0d ignored requests",
             sb.per_op[OP_CHAR], sb.per_op[OP_UNSIGNED], sb.per_op[OP_SIGNED],
             sb.per_op[OP_UNUSED]);
    $display("checked %0d display writes, %0d field errors", sb.writes_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
